// ===== rtl/sakth_pkg.sv =====
// shared types and constants for the suffix automaton substring ranker
// holds opcodes, datapath micro-operations and the controller/datapath structs
// no dependencies
package sakth_pkg;

  // fixed field widths
  localparam int OPC_W  = 2;
  localparam int LTR_W  = 5;
  localparam int RANK_W = 32;
  localparam int CNT_W  = 12;
  localparam int BIT_W  = 5;

  // transaction opcodes
  localparam logic [OPC_W-1:0] OPC_START  = 2'd0;
  localparam logic [OPC_W-1:0] OPC_APPEND = 2'd1;
  localparam logic [OPC_W-1:0] OPC_QUERY  = 2'd2;
  localparam logic [OPC_W-1:0] OPC_UNUSED = 2'd3;

  // datapath micro-operations
  typedef enum logic [5:0] {
    OP_NONE,
    OP_START,
    OP_LOAD,
    OP_ROOT_CLR,
    OP_ROW_CLR,
    OP_AP_NEW,
    OP_AP_LEN,
    OP_LINK_CUR_ROOT,
    OP_W_RD,
    OP_W1_SET,
    OP_W1_FOUND,
    OP_LP,
    OP_LINK_CUR_Q,
    OP_CLONE,
    OP_CL_LINK,
    OP_Q_LINK,
    OP_CUR_LINK,
    OP_CP_RD,
    OP_CP_WR,
    OP_W2_SET,
    OP_CN_INIT,
    OP_CN_RDL,
    OP_CN_BEGIN,
    OP_CN_RDT,
    OP_CN_RDC,
    OP_CN_ADD,
    OP_CN_WR,
    OP_IDX_INC,
    OP_CN_DONE,
    OP_CN_LVL,
    OP_CN_SNX,
    OP_RD_ROOT,
    OP_Q_SETUP,
    OP_DIV_STEP,
    OP_QW_BEGIN,
    OP_QT_RD,
    OP_QT_HOLD,
    OP_Q_HIT,
    OP_Q_MISS,
    OP_Q_EMIT,
    OP_Q_FIN
  } dp_op_t;

  // command from controller to datapath
  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic ap_bad;
    logic p_zero;
    logic tq_zero;
    logic tq_eq_q;
    logic len_eq;
    logic lvl_eq;
    logic idx_last;
    logic sidx_last;
    logic lvl_zero;
    logic counts_ready;
    logic need_div;
    logic div_last;
    logic walk_go;
    logic hit;
    logic has_pend;
    logic can_load;
  } status_t;

endpackage

// ===== rtl/sakth_ctrl.sv =====
// controller state machine for the suffix automaton substring ranker
// sequences start, append, path counting and query walks as datapath micro-operations
// depends on sakth_pkg
module sakth_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [sakth_pkg::OPC_W-1:0]  in_opcode,
  output logic                         in_stall,
  output sakth_pkg::cmd_t              cmd,
  input  sakth_pkg::status_t           sts
);

  localparam int SN = 33;

  typedef enum logic [SN-1:0] {
    ST_INIT = SN'(1) << 0,
    ST_IDLE = SN'(1) << 1,
    ST_AP0  = SN'(1) << 2,
    ST_AP1  = SN'(1) << 3,
    ST_CLR  = SN'(1) << 4,
    ST_W1R  = SN'(1) << 5,
    ST_W1C  = SN'(1) << 6,
    ST_W1P  = SN'(1) << 7,
    ST_W1Q  = SN'(1) << 8,
    ST_CL1  = SN'(1) << 9,
    ST_CL2  = SN'(1) << 10,
    ST_CL3  = SN'(1) << 11,
    ST_CPR  = SN'(1) << 12,
    ST_CPW  = SN'(1) << 13,
    ST_W2R  = SN'(1) << 14,
    ST_W2C  = SN'(1) << 15,
    ST_Q0   = SN'(1) << 16,
    ST_CNL  = SN'(1) << 17,
    ST_CNC  = SN'(1) << 18,
    ST_CNT  = SN'(1) << 19,
    ST_CNTC = SN'(1) << 20,
    ST_CNA  = SN'(1) << 21,
    ST_CNI  = SN'(1) << 22,
    ST_CNN  = SN'(1) << 23,
    ST_Q1   = SN'(1) << 24,
    ST_DIV  = SN'(1) << 25,
    ST_QW   = SN'(1) << 26,
    ST_QT   = SN'(1) << 27,
    ST_QTC  = SN'(1) << 28,
    ST_QCMP = SN'(1) << 29,
    ST_QNX  = SN'(1) << 30,
    ST_QEM  = SN'(1) << 31,
    ST_QFIN = SN'(1) << 32
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  sakth_pkg::dp_op_t op;

  // state register, reset enters the root clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and micro-operation
  always_comb begin
    state_nxt = state_r;
    op        = sakth_pkg::OP_NONE;
    unique case (state_r)
      ST_INIT: begin
        op = sakth_pkg::OP_ROOT_CLR;
        if (sts.idx_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_opcode)
            sakth_pkg::OPC_START: begin
              op        = sakth_pkg::OP_START;
              state_nxt = ST_INIT;
            end
            sakth_pkg::OPC_APPEND: begin
              op        = sakth_pkg::OP_LOAD;
              state_nxt = ST_AP0;
            end
            sakth_pkg::OPC_QUERY: begin
              op        = sakth_pkg::OP_LOAD;
              state_nxt = ST_Q0;
            end
            default: ;
          endcase
        end
      end
      // append: new state and its length
      ST_AP0: begin
        if (sts.ap_bad) begin
          state_nxt = ST_IDLE;
        end else begin
          op        = sakth_pkg::OP_AP_NEW;
          state_nxt = ST_AP1;
        end
      end
      ST_AP1: begin
        op        = sakth_pkg::OP_AP_LEN;
        state_nxt = ST_CLR;
      end
      ST_CLR: begin
        op = sakth_pkg::OP_ROW_CLR;
        if (sts.idx_last) state_nxt = ST_W1R;
      end
      // first suffix link walk
      ST_W1R: begin
        if (sts.p_zero) begin
          op        = sakth_pkg::OP_LINK_CUR_ROOT;
          state_nxt = ST_IDLE;
        end else begin
          op        = sakth_pkg::OP_W_RD;
          state_nxt = ST_W1C;
        end
      end
      ST_W1C: begin
        if (sts.tq_zero) begin
          op        = sakth_pkg::OP_W1_SET;
          state_nxt = ST_W1R;
        end else begin
          op        = sakth_pkg::OP_W1_FOUND;
          state_nxt = ST_W1P;
        end
      end
      ST_W1P: begin
        op        = sakth_pkg::OP_LP;
        state_nxt = ST_W1Q;
      end
      ST_W1Q: begin
        if (sts.len_eq) begin
          op        = sakth_pkg::OP_LINK_CUR_Q;
          state_nxt = ST_IDLE;
        end else begin
          op        = sakth_pkg::OP_CLONE;
          state_nxt = ST_CL1;
        end
      end
      // clone links and row copy
      ST_CL1: begin
        op        = sakth_pkg::OP_CL_LINK;
        state_nxt = ST_CL2;
      end
      ST_CL2: begin
        op        = sakth_pkg::OP_Q_LINK;
        state_nxt = ST_CL3;
      end
      ST_CL3: begin
        op        = sakth_pkg::OP_CUR_LINK;
        state_nxt = ST_CPR;
      end
      ST_CPR: begin
        op        = sakth_pkg::OP_CP_RD;
        state_nxt = ST_CPW;
      end
      ST_CPW: begin
        op        = sakth_pkg::OP_CP_WR;
        state_nxt = sts.idx_last ? ST_W2R : ST_CPR;
      end
      // second walk redirects to the clone
      ST_W2R: begin
        if (sts.p_zero) begin
          state_nxt = ST_IDLE;
        end else begin
          op        = sakth_pkg::OP_W_RD;
          state_nxt = ST_W2C;
        end
      end
      ST_W2C: begin
        if (sts.tq_eq_q) begin
          op        = sakth_pkg::OP_W2_SET;
          state_nxt = ST_W2R;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      // query entry, count paths first if stale
      ST_Q0: begin
        if (sts.counts_ready) begin
          op        = sakth_pkg::OP_RD_ROOT;
          state_nxt = ST_Q1;
        end else begin
          op        = sakth_pkg::OP_CN_INIT;
          state_nxt = ST_CNL;
        end
      end
      ST_CNL: begin
        op        = sakth_pkg::OP_CN_RDL;
        state_nxt = ST_CNC;
      end
      ST_CNC: begin
        if (sts.lvl_eq) begin
          op        = sakth_pkg::OP_CN_BEGIN;
          state_nxt = ST_CNT;
        end else begin
          state_nxt = ST_CNN;
        end
      end
      ST_CNT: begin
        op        = sakth_pkg::OP_CN_RDT;
        state_nxt = ST_CNTC;
      end
      ST_CNTC: begin
        if (sts.tq_zero) begin
          state_nxt = ST_CNI;
        end else begin
          op        = sakth_pkg::OP_CN_RDC;
          state_nxt = ST_CNA;
        end
      end
      ST_CNA: begin
        op        = sakth_pkg::OP_CN_ADD;
        state_nxt = ST_CNI;
      end
      ST_CNI: begin
        if (sts.idx_last) begin
          op        = sakth_pkg::OP_CN_WR;
          state_nxt = ST_CNN;
        end else begin
          op        = sakth_pkg::OP_IDX_INC;
          state_nxt = ST_CNT;
        end
      end
      ST_CNN: begin
        state_nxt = ST_CNL;
        if (!sts.sidx_last) begin
          op = sakth_pkg::OP_CN_SNX;
        end else if (sts.lvl_zero) begin
          op        = sakth_pkg::OP_CN_DONE;
          state_nxt = ST_Q0;
        end else begin
          op = sakth_pkg::OP_CN_LVL;
        end
      end
      // rank wrap
      ST_Q1: begin
        op        = sakth_pkg::OP_Q_SETUP;
        state_nxt = sts.need_div ? ST_DIV : ST_QW;
      end
      ST_DIV: begin
        op = sakth_pkg::OP_DIV_STEP;
        if (sts.div_last) state_nxt = ST_QW;
      end
      // rank walk
      ST_QW: begin
        if (sts.walk_go) begin
          op        = sakth_pkg::OP_QW_BEGIN;
          state_nxt = ST_QT;
        end else begin
          state_nxt = ST_QFIN;
        end
      end
      ST_QT: begin
        op        = sakth_pkg::OP_QT_RD;
        state_nxt = ST_QTC;
      end
      ST_QTC: begin
        if (sts.tq_zero) begin
          state_nxt = ST_QNX;
        end else begin
          op        = sakth_pkg::OP_QT_HOLD;
          state_nxt = ST_QCMP;
        end
      end
      ST_QCMP: begin
        if (sts.hit) begin
          op        = sakth_pkg::OP_Q_HIT;
          state_nxt = ST_QEM;
        end else begin
          op        = sakth_pkg::OP_Q_MISS;
          state_nxt = ST_QNX;
        end
      end
      ST_QNX: begin
        if (sts.idx_last) begin
          state_nxt = ST_QFIN;
        end else begin
          op        = sakth_pkg::OP_IDX_INC;
          state_nxt = ST_QT;
        end
      end
      ST_QEM: begin
        if (!sts.has_pend || sts.can_load) begin
          op        = sakth_pkg::OP_Q_EMIT;
          state_nxt = ST_QW;
        end
      end
      ST_QFIN: begin
        if (sts.can_load) begin
          op        = sakth_pkg::OP_Q_FIN;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  assign cmd.op   = op;
  assign in_stall = (state_r != ST_IDLE);

endmodule

// ===== rtl/sakth_dp.sv =====
// datapath for the suffix automaton substring ranker
// holds transition, link, length and path count memories, walk registers and output stage
// depends on sakth_pkg
module sakth_dp #(
  parameter int MAX_LEN  = 64,
  parameter int ALPHABET = 26
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sakth_pkg::cmd_t                    cmd,
  output sakth_pkg::status_t                 sts,
  input  logic [sakth_pkg::LTR_W-1:0]        in_letter,
  input  logic [sakth_pkg::RANK_W-1:0]       in_query_rank,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [sakth_pkg::LTR_W-1:0]        out_letter,
  output logic                               out_letter_valid,
  output logic                               out_last_of_answer
);

  localparam int NS   = 2 * MAX_LEN + 1;
  localparam int SW   = $clog2(NS);
  localparam int LW   = $clog2(MAX_LEN + 1);
  localparam int IW   = $clog2(ALPHABET);
  localparam int TAD  = NS * ALPHABET;
  localparam int TA_W = $clog2(TAD);
  localparam int CW   = sakth_pkg::CNT_W;
  localparam int RW   = sakth_pkg::RANK_W;

  // row address of a transition entry
  function automatic logic [TA_W-1:0] ta_addr(input logic [SW-1:0] row,
                                              input logic [IW-1:0] col);
    return TA_W'(TA_W'(row) * TA_W'(ALPHABET)) + TA_W'(col);
  endfunction

  // memories
  logic [SW-1:0] ta_mem [TAD];
  logic [SW-1:0] lk_mem [NS];
  logic [LW-1:0] ln_mem [NS];
  logic [CW-1:0] ct_mem [NS];

  logic [SW-1:0]   trans_q, link_q;
  logic [LW-1:0]   len_q;
  logic [CW-1:0]   cnt_q;

  logic            ta_we, lk_we, ln_we, ct_we;
  logic [TA_W-1:0] ta_raddr, ta_waddr;
  logic [SW-1:0]   ta_wdata;
  logic [SW-1:0]   lk_raddr, lk_waddr, lk_wdata;
  logic [SW-1:0]   ln_raddr, ln_waddr;
  logic [LW-1:0]   ln_wdata;
  logic [SW-1:0]   ct_raddr, ct_waddr;
  logic [CW-1:0]   ct_wdata;

  // registers
  logic [sakth_pkg::LTR_W-1:0] ltr_r;
  logic [RW-1:0]               rank_r;
  logic [SW-1:0]               total_r, last_r, cur_r, p_r, q_r, cl_r, node_r, t_r, sidx_r;
  logic [LW-1:0]               slen_r, lvl_r, lp_r, n_r;
  logic                        ready_r;
  logic [IW-1:0]               idx_r, pend_r;
  logic                        has_pend_r;
  logic [CW-1:0]               acc_r, dist_r, goal_r, num_r, rem_r;
  logic [sakth_pkg::BIT_W-1:0] bit_r;
  logic                        out_valid_r, out_lv_r, out_last_r;
  logic [sakth_pkg::LTR_W-1:0] out_letter_r;

  logic [IW-1:0]   col_ltr;
  logic [SW-1:0]   total_inc;
  logic [CW-1:0]   dist_nxt;
  logic [CW:0]     rem_sh, rem_sub;
  logic [CW-1:0]   rem_new;
  logic            can_load;
  logic            load_out;
  logic [sakth_pkg::LTR_W-1:0] load_letter;
  logic            load_lv, load_last;

  assign col_ltr   = ltr_r[IW-1:0];
  assign total_inc = SW'(total_r + 1'b1);
  assign dist_nxt  = (cnt_q == '0) ? '0 : CW'(cnt_q - 1'b1);
  assign rem_sh    = {rem_r, rank_r[RW-1]};
  assign rem_sub   = rem_sh - {1'b0, dist_r};
  assign rem_new   = (rem_sh >= {1'b0, dist_r}) ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
  assign can_load  = !out_valid_r || !out_stall;

  // status to the controller
  always_comb begin
    sts.ap_bad       = (ltr_r >= sakth_pkg::LTR_W'(ALPHABET)) ||
                       (slen_r >= LW'(MAX_LEN)) ||
                       ((32'(total_r) + 32'd2) >= 32'(NS));
    sts.p_zero       = (p_r == '0);
    sts.tq_zero      = (trans_q == '0);
    sts.tq_eq_q      = (trans_q == q_r);
    sts.len_eq       = (len_q == LW'(lp_r + 1'b1));
    sts.lvl_eq       = (len_q == lvl_r);
    sts.idx_last     = (idx_r == IW'(ALPHABET - 1));
    sts.sidx_last    = (sidx_r == total_r);
    sts.lvl_zero     = (lvl_r == '0);
    sts.counts_ready = ready_r;
    sts.need_div     = (dist_nxt != '0) && (rank_r > RW'(dist_nxt));
    sts.div_last     = &bit_r;
    sts.walk_go      = (num_r < goal_r) && (n_r < LW'(MAX_LEN));
    sts.hit          = ({1'b0, num_r} + {1'b0, cnt_q}) >= {1'b0, goal_r};
    sts.has_pend     = has_pend_r;
    sts.can_load     = can_load;
  end

  // memory port addressing
  always_comb begin
    ta_raddr = ta_addr(p_r, col_ltr);
    ta_we    = 1'b0;
    ta_waddr = ta_addr(p_r, col_ltr);
    ta_wdata = '0;
    lk_raddr = p_r;
    lk_we    = 1'b0;
    lk_waddr = cur_r;
    lk_wdata = '0;
    ln_raddr = p_r;
    ln_we    = 1'b0;
    ln_waddr = cur_r;
    ln_wdata = '0;
    ct_raddr = trans_q;
    ct_we    = 1'b0;
    ct_waddr = sidx_r;
    ct_wdata = acc_r;
    unique case (cmd.op)
      sakth_pkg::OP_ROOT_CLR: begin
        ta_we    = 1'b1;
        ta_waddr = ta_addr(cur_r, idx_r);
        lk_we    = 1'b1;
        ln_we    = 1'b1;
      end
      sakth_pkg::OP_ROW_CLR: begin
        ta_we    = 1'b1;
        ta_waddr = ta_addr(cur_r, idx_r);
      end
      sakth_pkg::OP_AP_NEW: ln_raddr = last_r;
      sakth_pkg::OP_AP_LEN: begin
        ln_we    = 1'b1;
        ln_wdata = LW'(len_q + 1'b1);
        lk_we    = 1'b1;
      end
      sakth_pkg::OP_LINK_CUR_ROOT: begin
        lk_we    = 1'b1;
        lk_wdata = SW'(1);
      end
      sakth_pkg::OP_W1_SET: begin
        ta_we    = 1'b1;
        ta_wdata = cur_r;
      end
      sakth_pkg::OP_LP: ln_raddr = q_r;
      sakth_pkg::OP_LINK_CUR_Q: begin
        lk_we    = 1'b1;
        lk_wdata = q_r;
      end
      sakth_pkg::OP_CLONE: begin
        ln_we    = 1'b1;
        ln_waddr = total_inc;
        ln_wdata = LW'(lp_r + 1'b1);
        lk_raddr = q_r;
      end
      sakth_pkg::OP_CL_LINK: begin
        lk_we    = 1'b1;
        lk_waddr = cl_r;
        lk_wdata = link_q;
      end
      sakth_pkg::OP_Q_LINK: begin
        lk_we    = 1'b1;
        lk_waddr = q_r;
        lk_wdata = cl_r;
      end
      sakth_pkg::OP_CUR_LINK: begin
        lk_we    = 1'b1;
        lk_wdata = cl_r;
      end
      sakth_pkg::OP_CP_RD: ta_raddr = ta_addr(q_r, idx_r);
      sakth_pkg::OP_CP_WR: begin
        ta_we    = 1'b1;
        ta_waddr = ta_addr(cl_r, idx_r);
        ta_wdata = trans_q;
      end
      sakth_pkg::OP_W2_SET: begin
        ta_we    = 1'b1;
        ta_wdata = cl_r;
      end
      sakth_pkg::OP_CN_RDL: ln_raddr = sidx_r;
      sakth_pkg::OP_CN_RDT: ta_raddr = ta_addr(sidx_r, idx_r);
      sakth_pkg::OP_CN_WR:  ct_we = 1'b1;
      sakth_pkg::OP_RD_ROOT: ct_raddr = SW'(1);
      sakth_pkg::OP_QT_RD: ta_raddr = ta_addr(node_r, idx_r);
      default: ;
    endcase
  end

  // transition memory
  always_ff @(posedge clk) begin
    if (ta_we) ta_mem[ta_waddr] <= ta_wdata;
    trans_q <= ta_mem[ta_raddr];
  end

  // suffix link memory
  always_ff @(posedge clk) begin
    if (lk_we) lk_mem[lk_waddr] <= lk_wdata;
    link_q <= lk_mem[lk_raddr];
  end

  // state length memory
  always_ff @(posedge clk) begin
    if (ln_we) ln_mem[ln_waddr] <= ln_wdata;
    len_q <= ln_mem[ln_raddr];
  end

  // path count memory
  always_ff @(posedge clk) begin
    if (ct_we) ct_mem[ct_waddr] <= ct_wdata;
    cnt_q <= ct_mem[ct_raddr];
  end

  // output stage load selection
  always_comb begin
    load_out    = 1'b0;
    load_letter = '0;
    load_lv     = 1'b0;
    load_last   = 1'b0;
    if (cmd.op == sakth_pkg::OP_Q_EMIT && has_pend_r) begin
      load_out    = 1'b1;
      load_letter = sakth_pkg::LTR_W'(pend_r);
      load_lv     = 1'b1;
    end else if (cmd.op == sakth_pkg::OP_Q_FIN) begin
      load_out    = 1'b1;
      load_letter = has_pend_r ? sakth_pkg::LTR_W'(pend_r) : '0;
      load_lv     = has_pend_r;
      load_last   = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= SW'(1);
      last_r      <= SW'(1);
      cur_r       <= SW'(1);
      slen_r      <= '0;
      ready_r     <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        sakth_pkg::OP_START: begin
          total_r <= SW'(1);
          last_r  <= SW'(1);
          cur_r   <= SW'(1);
          slen_r  <= '0;
          ready_r <= 1'b0;
          idx_r   <= '0;
        end
        sakth_pkg::OP_ROOT_CLR, sakth_pkg::OP_ROW_CLR,
        sakth_pkg::OP_CP_WR, sakth_pkg::OP_IDX_INC: idx_r <= IW'(idx_r + 1'b1);
        sakth_pkg::OP_AP_NEW: begin
          slen_r  <= LW'(slen_r + 1'b1);
          ready_r <= 1'b0;
          cur_r   <= total_inc;
          total_r <= total_inc;
          last_r  <= total_inc;
        end
        sakth_pkg::OP_AP_LEN, sakth_pkg::OP_CLONE,
        sakth_pkg::OP_CN_BEGIN, sakth_pkg::OP_QW_BEGIN: idx_r <= '0;
        sakth_pkg::OP_CN_DONE: ready_r <= 1'b1;
        default: ;
      endcase
      if (cmd.op == sakth_pkg::OP_CLONE) total_r <= total_inc;
    end
  end

  // walk and payload registers
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_letter_r <= load_letter;
      out_lv_r     <= load_lv;
      out_last_r   <= load_last;
    end
    case (cmd.op)
      sakth_pkg::OP_LOAD: begin
        ltr_r  <= in_letter;
        rank_r <= in_query_rank;
      end
      sakth_pkg::OP_AP_NEW:   p_r <= last_r;
      sakth_pkg::OP_AP_LEN:   lp_r <= len_q;
      sakth_pkg::OP_W1_SET, sakth_pkg::OP_W2_SET: p_r <= link_q;
      sakth_pkg::OP_W1_FOUND: q_r <= trans_q;
      sakth_pkg::OP_LP:       lp_r <= len_q;
      sakth_pkg::OP_CLONE:    cl_r <= total_inc;
      sakth_pkg::OP_CN_INIT: begin
        lvl_r  <= slen_r;
        sidx_r <= SW'(1);
      end
      sakth_pkg::OP_CN_BEGIN: acc_r <= CW'(1);
      sakth_pkg::OP_CN_ADD:   acc_r <= CW'(acc_r + cnt_q);
      sakth_pkg::OP_CN_LVL: begin
        lvl_r  <= LW'(lvl_r - 1'b1);
        sidx_r <= SW'(1);
      end
      sakth_pkg::OP_CN_SNX:   sidx_r <= SW'(sidx_r + 1'b1);
      sakth_pkg::OP_Q_SETUP: begin
        dist_r     <= dist_nxt;
        goal_r     <= (dist_nxt == '0) ? '0 : rank_r[CW-1:0];
        num_r      <= '0;
        node_r     <= SW'(1);
        n_r        <= '0;
        has_pend_r <= 1'b0;
        rem_r      <= '0;
        bit_r      <= '0;
      end
      sakth_pkg::OP_DIV_STEP: begin
        rem_r  <= rem_new;
        goal_r <= rem_new;
        rank_r <= {rank_r[RW-2:0], 1'b0};
        bit_r  <= sakth_pkg::BIT_W'(bit_r + 1'b1);
      end
      sakth_pkg::OP_QT_HOLD:  t_r <= trans_q;
      sakth_pkg::OP_Q_HIT: begin
        node_r <= t_r;
        num_r  <= CW'(num_r + 1'b1);
      end
      sakth_pkg::OP_Q_MISS:   num_r <= CW'(num_r + cnt_q);
      sakth_pkg::OP_Q_EMIT: begin
        pend_r     <= idx_r;
        has_pend_r <= 1'b1;
        n_r        <= LW'(n_r + 1'b1);
      end
      default: ;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_letter         = out_letter_r;
  assign out_letter_valid   = out_lv_r;
  assign out_last_of_answer = out_last_r;

`ifndef SYNTHESIS
  // state numbering never passes the automaton's capacity
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(total_r) < 32'(NS))
    else $error("state total beyond capacity");

  // the final item of an answer is presented after the finishing step
  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == sakth_pkg::OP_Q_FIN |=> out_valid_r && out_last_r)
    else $error("finishing step did not present a final item");

  // a walk only starts with a wrapped goal inside the distinct count
  a_goal_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == sakth_pkg::OP_QW_BEGIN |-> goal_r != '0 && goal_r <= dist_r)
    else $error("walk goal out of range");

  // an emitted letter carries a valid flag, an empty answer does not
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_lv_r |-> out_last_r)
    else $error("empty answer item not final");
`endif

endmodule

// ===== rtl/suffix_automaton_kth_substring.sv =====
// start: clears the root row; an ignored append returns to idle, others
//   create a state and walk suffix links, a clone also copies its row and redirects links
// query: a stale path count is recomputed first, then the rank is wrapped when needed,
//   then letters are tried per node and each chosen letter is emitted
// throughput: one transaction at a time, the next is taken once the current one is done
// reset: synchronous, the root row is cleared while input is stalled
module suffix_automaton_kth_substring #(
  parameter int MAX_LEN  = 64,
  parameter int ALPHABET = 26
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sakth_pkg::OPC_W-1:0]   in_opcode,
  input  logic [sakth_pkg::LTR_W-1:0]   in_letter,
  input  logic [sakth_pkg::RANK_W-1:0]  in_query_rank,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sakth_pkg::LTR_W-1:0]   out_letter,
  output logic                          out_letter_valid,
  output logic                          out_last_of_answer
);

  sakth_pkg::cmd_t    cmd;
  sakth_pkg::status_t sts;

  // sequencing
  sakth_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // memories and walk registers
  sakth_dp #(
    .MAX_LEN  (MAX_LEN),
    .ALPHABET (ALPHABET)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_letter          (in_letter),
    .in_query_rank      (in_query_rank),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_letter         (out_letter),
    .out_letter_valid   (out_letter_valid),
    .out_last_of_answer (out_last_of_answer)
  );

endmodule
